// ===== hw/rtl/ssa_pkg.sv =====
// Package for the slab slot allocator: field widths, sizes, status and
// command codes, controller states and the file memory write request.
// Depends on nothing; every other file imports it.
package ssa_pkg;

  localparam int FILE_W         = 4;
  localparam int SLOT_W         = 6;
  localparam int COUNT_W        = 7;
  localparam int SLOTS_PER_FILE = 64;
  localparam int MAX_FILES      = 16;
  localparam int STACK_DEPTH    = 1024;
  localparam int STACK_AW       = 10;
  localparam int FCOUNT_W       = 11;
  localparam int CUR_W          = 5;

  localparam logic [CUR_W-1:0] NO_FILE = '1;

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NO_SPACE = 2'd1,
    ST_OVERFLOW = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_POP,
    S_EXEC
  } state_t;

  typedef struct packed {
    logic                      en;
    logic [FILE_W-1:0]         addr;
    logic [COUNT_W-1:0]        count;
    logic [SLOTS_PER_FILE-1:0] map;
  } file_wr_t;

endpackage

// ===== hw/rtl/ssa_file_mem.sv =====
// Per-file state memory: used-slot count and occupancy bitmap per file.
// Synchronous, registered read; a valid bit per entry makes
// never-written entries read as zero. Depends on ssa_pkg.
module ssa_file_mem (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              rd_en,
  input  logic [ssa_pkg::FILE_W-1:0]        rd_addr,
  input  ssa_pkg::file_wr_t                 wr,
  output logic [ssa_pkg::COUNT_W-1:0]       rd_count,
  output logic [ssa_pkg::SLOTS_PER_FILE-1:0] rd_map
);
  import ssa_pkg::*;

  localparam int DW = COUNT_W + SLOTS_PER_FILE;

  logic [DW-1:0]        mem [MAX_FILES];
  logic [MAX_FILES-1:0] vld_r;
  logic [DW-1:0]        rd_data_r;
  logic                 rd_vld_r;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= {wr.count, wr.map};
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (wr.en) begin
        vld_r[wr.addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_vld_r <= vld_r[rd_addr];
      end
    end
  end

  assign rd_count = rd_vld_r ? rd_data_r[DW-1:SLOTS_PER_FILE] : '0;
  assign rd_map   = rd_vld_r ? rd_data_r[SLOTS_PER_FILE-1:0] : '0;

endmodule

// ===== hw/rtl/ssa_free_stack.sv =====
// Free stack storage: one entry per freed slot, {file, slot}.
// Single write port, single synchronous read port. Depends on ssa_pkg.
module ssa_free_stack (
  input  logic                                  clk,
  input  logic                                  wr_en,
  input  logic [ssa_pkg::STACK_AW-1:0]          wr_addr,
  input  logic [ssa_pkg::FILE_W+ssa_pkg::SLOT_W-1:0] wr_data,
  input  logic                                  rd_en,
  input  logic [ssa_pkg::STACK_AW-1:0]          rd_addr,
  output logic [ssa_pkg::FILE_W+ssa_pkg::SLOT_W-1:0] rd_data
);
  import ssa_pkg::*;

  logic [FILE_W+SLOT_W-1:0] mem [STACK_DEPTH];
  logic [FILE_W+SLOT_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== hw/rtl/slab_slot_allocator_unit.sv =====
// Slab slot allocator top level: command controller around the file memory
// and the free stack; depends on ssa_pkg. An accepted item goes through the
// EXEC state (through POP first for an allocate served from the free stack),
// and its result strobe is registered from EXEC. A new item may be accepted in
// the cycle its predecessor's result is shown, not before. Synchronous reset
// empties the stack, closes all files and zeroes all counts; no result stalls.
module slab_slot_allocator_unit (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic                          in_command,
  input  logic [ssa_pkg::FILE_W-1:0]    in_free_file,
  input  logic [ssa_pkg::SLOT_W-1:0]    in_free_slot,
  output logic                          out_valid,
  output logic [1:0]                    out_status,
  output logic [ssa_pkg::FILE_W-1:0]    out_slot_file,
  output logic [ssa_pkg::SLOT_W-1:0]    out_slot_index,
  output logic [ssa_pkg::COUNT_W-1:0]   out_used_in_file,
  output logic                          out_opened_file
);
  import ssa_pkg::*;

  state_t               state_r, state_nxt;
  logic [CUR_W-1:0]     cur_file_r, cur_file_nxt;
  logic [COUNT_W-1:0]   next_slot_r, next_slot_nxt;
  logic [FCOUNT_W-1:0]  free_count_r, free_count_nxt;

  logic                 op_free_r, op_free_nxt;
  logic                 op_nospace_r, op_nospace_nxt;
  logic                 op_overflow_r, op_overflow_nxt;
  logic                 op_opened_r, op_opened_nxt;
  logic [FILE_W-1:0]    op_file_r, op_file_nxt;
  logic [SLOT_W-1:0]    op_slot_r, op_slot_nxt;

  logic                 out_valid_r;
  status_t              out_status_r, res_status;
  logic [FILE_W-1:0]    out_file_r, res_file;
  logic [SLOT_W-1:0]    out_slot_r, res_slot;
  logic [COUNT_W-1:0]   out_used_r, res_used;
  logic                 out_opened_r, res_opened;

  logic                 accept;
  logic                 fm_rd_en;
  logic [FILE_W-1:0]    fm_rd_addr;
  file_wr_t             fm_wr;
  logic [COUNT_W-1:0]   fm_rd_count;
  logic [SLOTS_PER_FILE-1:0] fm_rd_map;

  logic                 stk_wr_en, stk_rd_en;
  logic [STACK_AW-1:0]  stk_wr_addr, stk_rd_addr;
  logic [FILE_W+SLOT_W-1:0] stk_wr_data, stk_rd_data;

  logic [SLOTS_PER_FILE-1:0] slot_bit;
  logic [CUR_W-1:0]     new_file;

  assign accept = start && (state_r == S_IDLE);
  assign busy   = (state_r != S_IDLE);

  // Slot 0 is the most significant bit of a file's bitmap.
  assign slot_bit = {1'b1, {(SLOTS_PER_FILE-1){1'b0}}} >> op_slot_r;

  always_comb begin
    state_nxt       = state_r;
    cur_file_nxt    = cur_file_r;
    next_slot_nxt   = next_slot_r;
    free_count_nxt  = free_count_r;
    op_free_nxt     = op_free_r;
    op_nospace_nxt  = op_nospace_r;
    op_overflow_nxt = op_overflow_r;
    op_opened_nxt   = op_opened_r;
    op_file_nxt     = op_file_r;
    op_slot_nxt     = op_slot_r;
    fm_rd_en        = 1'b0;
    fm_rd_addr      = op_file_r;
    stk_wr_en       = 1'b0;
    stk_wr_addr     = free_count_r[STACK_AW-1:0];
    stk_wr_data     = {in_free_file, in_free_slot};
    stk_rd_en       = 1'b0;
    stk_rd_addr     = free_count_r[STACK_AW-1:0] - 1'b1;
    new_file        = (cur_file_r == NO_FILE) ? '0 : cur_file_r + 1'b1;
    fm_wr           = '0;
    res_status      = ST_OK;
    res_file        = op_file_r;
    res_slot        = op_slot_r;
    res_used        = '0;
    res_opened      = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          op_free_nxt     = (in_command == CMD_FREE);
          op_nospace_nxt  = 1'b0;
          op_overflow_nxt = 1'b0;
          op_opened_nxt   = 1'b0;
          state_nxt       = S_EXEC;
          if (in_command == CMD_FREE) begin
            op_file_nxt = in_free_file;
            op_slot_nxt = in_free_slot;
            fm_rd_en    = 1'b1;
            fm_rd_addr  = in_free_file;
            if (free_count_r == FCOUNT_W'(STACK_DEPTH)) begin
              op_overflow_nxt = 1'b1;
            end else begin
              // The push needs no file data, so it lands right away.
              stk_wr_en      = 1'b1;
              free_count_nxt = free_count_r + 1'b1;
            end
          end else if (free_count_r != '0) begin
            stk_rd_en      = 1'b1;
            free_count_nxt = free_count_r - 1'b1;
            state_nxt      = S_POP;
          end else if (cur_file_r != NO_FILE &&
                       next_slot_r < COUNT_W'(SLOTS_PER_FILE)) begin
            op_file_nxt   = cur_file_r[FILE_W-1:0];
            op_slot_nxt   = next_slot_r[SLOT_W-1:0];
            next_slot_nxt = next_slot_r + 1'b1;
            fm_rd_en      = 1'b1;
            fm_rd_addr    = cur_file_r[FILE_W-1:0];
          end else if (new_file >= CUR_W'(MAX_FILES)) begin
            op_nospace_nxt = 1'b1;
          end else begin
            cur_file_nxt  = new_file;
            next_slot_nxt = COUNT_W'(1);
            op_opened_nxt = 1'b1;
            op_file_nxt   = new_file[FILE_W-1:0];
            op_slot_nxt   = '0;
            fm_rd_en      = 1'b1;
            fm_rd_addr    = new_file[FILE_W-1:0];
          end
        end
      end
      S_POP: begin
        op_file_nxt = stk_rd_data[FILE_W+SLOT_W-1:SLOT_W];
        op_slot_nxt = stk_rd_data[SLOT_W-1:0];
        fm_rd_en    = 1'b1;
        fm_rd_addr  = stk_rd_data[FILE_W+SLOT_W-1:SLOT_W];
        state_nxt   = S_EXEC;
      end
      S_EXEC: begin
        state_nxt = S_IDLE;
        if (op_nospace_r) begin
          res_status = ST_NO_SPACE;
          res_file   = '0;
          res_slot   = '0;
        end else if (op_free_r) begin
          if (op_overflow_r) begin
            res_status = ST_OVERFLOW;
            res_used   = fm_rd_count;
          end else begin
            res_used   = fm_rd_count - 1'b1;
            fm_wr.en   = 1'b1;
            fm_wr.addr = op_file_r;
            fm_wr.count = res_used;
            fm_wr.map  = fm_rd_map ^ slot_bit;
          end
        end else begin
          res_used    = fm_rd_count + 1'b1;
          res_opened  = op_opened_r;
          fm_wr.en    = 1'b1;
          fm_wr.addr  = op_file_r;
          fm_wr.count = res_used;
          fm_wr.map   = fm_rd_map | slot_bit;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      cur_file_r   <= NO_FILE;
      next_slot_r  <= COUNT_W'(SLOTS_PER_FILE);
      free_count_r <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      cur_file_r   <= cur_file_nxt;
      next_slot_r  <= next_slot_nxt;
      free_count_r <= free_count_nxt;
      out_valid_r  <= (state_r == S_EXEC);
    end
  end

  always_ff @(posedge clk) begin
    op_free_r     <= op_free_nxt;
    op_nospace_r  <= op_nospace_nxt;
    op_overflow_r <= op_overflow_nxt;
    op_opened_r   <= op_opened_nxt;
    op_file_r     <= op_file_nxt;
    op_slot_r     <= op_slot_nxt;
    if (state_r == S_EXEC) begin
      out_status_r <= res_status;
      out_file_r   <= res_file;
      out_slot_r   <= res_slot;
      out_used_r   <= res_used;
      out_opened_r <= res_opened;
    end
  end

  ssa_file_mem u_file_mem (
    .clk      (clk),
    .rst_n    (rst_n),
    .rd_en    (fm_rd_en),
    .rd_addr  (fm_rd_addr),
    .wr       (fm_wr),
    .rd_count (fm_rd_count),
    .rd_map   (fm_rd_map)
  );

  ssa_free_stack u_free_stack (
    .clk     (clk),
    .wr_en   (stk_wr_en),
    .wr_addr (stk_wr_addr),
    .wr_data (stk_wr_data),
    .rd_en   (stk_rd_en),
    .rd_addr (stk_rd_addr),
    .rd_data (stk_rd_data)
  );

  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_slot_file    = out_file_r;
  assign out_slot_index   = out_slot_r;
  assign out_used_in_file = out_used_r;
  assign out_opened_file  = out_opened_r;

  a_result_follows_exec: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(state_r == S_EXEC))
    else $error("result strobe without a completed item");

  a_stack_bound: assert property (@(posedge clk) disable iff (!rst_n)
    free_count_r <= FCOUNT_W'(STACK_DEPTH))
    else $error("free stack count beyond its depth");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> busy)
    else $error("accepted item did not make the block busy");

  a_nospace_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == ST_NO_SPACE) |->
      (out_slot_file == '0 && out_slot_index == '0 &&
       out_used_in_file == '0 && !out_opened_file))
    else $error("out-of-space result carries nonzero fields");

endmodule

// ===== dv/slot_result_checker.sv =====
// Result checker for the slab slot allocator: keeps its own copy of the stack,
// file counts and bitmaps, predicts each item's result and compares the strobed
// result. Depends on ssa_pkg.
`timescale 1ns / 100ps

module slot_result_checker (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic                         busy,
  input  logic                         in_command,
  input  logic [ssa_pkg::FILE_W-1:0]   in_free_file,
  input  logic [ssa_pkg::SLOT_W-1:0]   in_free_slot,
  input  logic                         out_valid,
  input  logic [1:0]                   out_status,
  input  logic [ssa_pkg::FILE_W-1:0]   out_slot_file,
  input  logic [ssa_pkg::SLOT_W-1:0]   out_slot_index,
  input  logic [ssa_pkg::COUNT_W-1:0]  out_used_in_file,
  input  logic                         out_opened_file,
  output int                           n_failures,
  output int                           n_pending
);
  import ssa_pkg::*;

  typedef struct packed {
    status_t              status;
    logic [FILE_W-1:0]    file;
    logic [SLOT_W-1:0]    slot;
    logic [COUNT_W-1:0]   used;
    logic                 opened;
  } slot_result_t;

  // Allocator state as the block should hold it.
  logic [CUR_W-1:0]          cur_file;
  logic [COUNT_W-1:0]        bump_slot;
  logic [STACK_AW-1:0]       freed_slots [STACK_DEPTH];
  logic [FCOUNT_W-1:0]       stack_fill;
  logic [COUNT_W-1:0]        used_cnt [MAX_FILES];
  logic [SLOTS_PER_FILE-1:0] occupancy [MAX_FILES];

  slot_result_t due_results[$];
  int fails = 0;
  int results_checked = 0;

  task automatic flag_mismatch(input string msg);
    fails++;
    if (fails <= 40) $display("MISMATCH at %0t: %s", $time, msg);
  endtask

  task automatic clear_state();
    cur_file   = NO_FILE;
    bump_slot  = COUNT_W'(SLOTS_PER_FILE);
    stack_fill = '0;
    for (int i = 0; i < MAX_FILES; i++) begin
      used_cnt[i]  = '0;
      occupancy[i] = '0;
    end
  endtask

  // Applies one command to the shadow state and returns the result it causes.
  function automatic slot_result_t allocate_or_release(input logic cmd,
      input logic [FILE_W-1:0] ff, input logic [SLOT_W-1:0] fs);
    slot_result_t r;
    logic [CUR_W-1:0] nf;
    logic [FILE_W-1:0] f;
    logic [SLOT_W-1:0] s;
    r = '0;
    r.status = ST_OK;
    if (cmd == CMD_FREE) begin
      r.file = ff;
      r.slot = fs;
      if (stack_fill == STACK_DEPTH) begin
        r.status = ST_OVERFLOW;
        r.used   = used_cnt[ff];
        return r;
      end
      freed_slots[stack_fill[STACK_AW-1:0]] = {ff, fs};
      stack_fill = stack_fill + 1'b1;
      // A free of a slot that is not in use still toggles and wraps the count.
      used_cnt[ff] = used_cnt[ff] - 1'b1;
      occupancy[ff][SLOTS_PER_FILE-1-fs] = ~occupancy[ff][SLOTS_PER_FILE-1-fs];
      r.used = used_cnt[ff];
      return r;
    end
    if (stack_fill != 0) begin
      stack_fill = stack_fill - 1'b1;
      {f, s} = freed_slots[stack_fill[STACK_AW-1:0]];
    end else if (cur_file != NO_FILE && bump_slot < SLOTS_PER_FILE) begin
      f = cur_file[FILE_W-1:0];
      s = bump_slot[SLOT_W-1:0];
      bump_slot = bump_slot + 1'b1;
    end else begin
      nf = (cur_file == NO_FILE) ? '0 : cur_file + 1'b1;
      if (nf >= MAX_FILES) begin
        r.status = ST_NO_SPACE;
        return r;
      end
      cur_file  = nf;
      f         = nf[FILE_W-1:0];
      s         = '0;
      bump_slot = COUNT_W'(1);
      r.opened  = 1'b1;
    end
    used_cnt[f] = used_cnt[f] + 1'b1;
    occupancy[f][SLOTS_PER_FILE-1-s] = 1'b1;
    r.file = f;
    r.slot = s;
    r.used = used_cnt[f];
    return r;
  endfunction

  task automatic check_result();
    slot_result_t want;
    if (due_results.size() == 0) begin
      flag_mismatch($sformatf("result with no item waiting: status %0d file %0d slot %0d",
                              out_status, out_slot_file, out_slot_index));
      return;
    end
    want = due_results.pop_front();
    if (out_status != want.status)
      flag_mismatch($sformatf("result %0d status %0d, expected %0d",
                              results_checked, out_status, want.status));
    if (out_slot_file != want.file)
      flag_mismatch($sformatf("result %0d slot_file %0d, expected %0d",
                              results_checked, out_slot_file, want.file));
    if (out_slot_index != want.slot)
      flag_mismatch($sformatf("result %0d slot_index %0d, expected %0d",
                              results_checked, out_slot_index, want.slot));
    if (out_used_in_file != want.used)
      flag_mismatch($sformatf("result %0d used_in_file %0d, expected %0d",
                              results_checked, out_used_in_file, want.used));
    if (out_opened_file != want.opened)
      flag_mismatch($sformatf("result %0d opened_file %0d, expected %0d",
                              results_checked, out_opened_file, want.opened));
    results_checked++;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      clear_state();
      due_results.delete();
    end else begin
      // The result on this edge always belongs to an earlier item.
      if (out_valid) check_result();
      if (start && !busy)
        due_results.push_back(allocate_or_release(in_command, in_free_file, in_free_slot));
    end
    n_pending  <= due_results.size();
    n_failures <= fails;
  end

endmodule

// ===== dv/testbench.sv =====
// Top of the slab slot allocator testbench: clock, reset and command stimulus
// with random gaps; checking is done by slot_result_checker.
// Depends on ssa_pkg, slab_slot_allocator_unit and slot_result_checker.
`timescale 1ns / 100ps

module testbench;
  import ssa_pkg::*;

  localparam int RANDOM_ITEMS = 850;
  localparam int LIMIT_CYCLES = 2000000;

  logic                clk;
  logic                rst_n;
  logic                start;
  logic                busy;
  logic                in_command;
  logic [FILE_W-1:0]   in_free_file;
  logic [SLOT_W-1:0]   in_free_slot;
  logic                out_valid;
  logic [1:0]          out_status;
  logic [FILE_W-1:0]   out_slot_file;
  logic [SLOT_W-1:0]   out_slot_index;
  logic [COUNT_W-1:0]  out_used_in_file;
  logic                out_opened_file;
  int                  n_failures;
  int                  n_pending;

  int   cycles = 0;
  int   items_sent = 0;
  int   results_seen = 0;
  int   no_space_seen = 0;
  int   overflow_seen = 0;
  bit   no_gaps = 0;
  logic in_flight_cmds[$];
  logic [FILE_W+SLOT_W-1:0] granted_slots[$];

  slab_slot_allocator_unit i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_command       (in_command),
    .in_free_file     (in_free_file),
    .in_free_slot     (in_free_slot),
    .out_valid        (out_valid),
    .out_status       (out_status),
    .out_slot_file    (out_slot_file),
    .out_slot_index   (out_slot_index),
    .out_used_in_file (out_used_in_file),
    .out_opened_file  (out_opened_file)
  );

  slot_result_checker i_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_command       (in_command),
    .in_free_file     (in_free_file),
    .in_free_slot     (in_free_slot),
    .out_valid        (out_valid),
    .out_status       (out_status),
    .out_slot_file    (out_slot_file),
    .out_slot_index   (out_slot_index),
    .out_used_in_file (out_used_in_file),
    .out_opened_file  (out_opened_file),
    .n_failures       (n_failures),
    .n_pending        (n_pending)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= LIMIT_CYCLES) begin
      $display("testbench: errors");
      $finish;
    end
  end

  // Granted slots feed the free commands of the random part, so most frees
  // release something that is really in use.
  always @(posedge clk) begin
    logic cmd;
    if (rst_n && out_valid) begin
      results_seen++;
      if (out_status == ST_NO_SPACE) no_space_seen++;
      if (out_status == ST_OVERFLOW) overflow_seen++;
      if (in_flight_cmds.size() != 0) begin
        cmd = in_flight_cmds.pop_front();
        if (cmd == CMD_ALLOC && out_status == ST_OK && granted_slots.size() < 256)
          granted_slots.push_back({out_slot_file, out_slot_index});
      end
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic idle_for(input int n);
    if (n > 0) begin
      start        <= 1'b0;
      in_command   <= 1'($urandom_range(0, 1));
      in_free_file <= FILE_W'($urandom);
      in_free_slot <= SLOT_W'($urandom);
      repeat (n) @(posedge clk);
    end
  endtask

  // Holds the item on the ports until the block takes it.
  task automatic send_item(input logic cmd, input logic [FILE_W-1:0] f,
                           input logic [SLOT_W-1:0] s);
    idle_for(no_gaps ? 0 : pick_gap());
    start        <= 1'b1;
    in_command   <= cmd;
    in_free_file <= f;
    in_free_slot <= s;
    @(posedge clk);
    while (busy) @(posedge clk);
    in_flight_cmds.push_back(cmd);
    items_sent++;
  endtask

  task automatic send_random_free();
    int idx;
    logic [FILE_W+SLOT_W-1:0] pick;
    if (granted_slots.size() != 0 && $urandom_range(0, 99) < 75) begin
      idx  = $urandom_range(0, granted_slots.size() - 1);
      pick = granted_slots[idx];
      granted_slots.delete(idx);
      send_item(CMD_FREE, pick[FILE_W+SLOT_W-1:SLOT_W], pick[SLOT_W-1:0]);
    end else begin
      send_item(CMD_FREE, FILE_W'($urandom), SLOT_W'($urandom));
    end
  endtask

  initial begin
    rst_n        <= 1'b0;
    start        <= 1'b0;
    in_command   <= CMD_ALLOC;
    in_free_file <= '0;
    in_free_slot <= '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: a free before any allocate wraps the count below zero, then
    // reuse from the stack, file opening, field extremes and a double free.
    send_item(CMD_FREE, 4'd0, 6'd5);
    send_item(CMD_ALLOC, 4'd0, 6'd0);
    send_item(CMD_ALLOC, 4'd15, 6'd63);
    send_item(CMD_ALLOC, 4'd0, 6'd0);
    send_item(CMD_FREE, 4'd15, 6'd63);
    send_item(CMD_FREE, 4'd0, 6'd0);
    send_item(CMD_ALLOC, 4'd0, 6'd0);
    send_item(CMD_ALLOC, 4'd0, 6'd0);
    send_item(CMD_ALLOC, 4'd15, 6'd63);
    send_item(CMD_FREE, 4'd10, 6'd42);
    send_item(CMD_FREE, 4'd5, 6'd21);
    send_item(CMD_FREE, 4'd5, 6'd21);
    send_item(CMD_ALLOC, 4'd0, 6'd0);
    send_item(CMD_ALLOC, 4'd0, 6'd0);
    send_item(CMD_ALLOC, 4'd0, 6'd0);
    send_item(CMD_FREE, 4'd0, 6'd1);
    send_item(CMD_FREE, 4'd0, 6'd2);
    send_item(CMD_ALLOC, 4'd0, 6'd0);
    send_item(CMD_ALLOC, 4'd0, 6'd0);
    send_item(CMD_ALLOC, 4'd0, 6'd0);

    // Random mix, in blocks of 40 items that are each gapped or back-to-back at random.
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i % 40 == 0) no_gaps = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 99) < 55)
        send_item(CMD_ALLOC, FILE_W'($urandom), SLOT_W'($urandom));
      else send_random_free();
    end
    no_gaps = 0;

    // Allocate until every file is used up, then reuse one freed slot.
    for (int i = 0; i < 3000 && no_space_seen < 3; i++)
      send_item(CMD_ALLOC, FILE_W'($urandom), SLOT_W'($urandom));
    send_item(CMD_FREE, 4'd3, 6'd7);
    send_item(CMD_ALLOC, 4'd0, 6'd0);
    send_item(CMD_ALLOC, 4'd0, 6'd0);

    // Free until the stack is full and frees start to be refused.
    for (int i = 0; i < 1300 && overflow_seen < 3; i++)
      send_item(CMD_FREE, FILE_W'($urandom), SLOT_W'($urandom));
    send_item(CMD_ALLOC, 4'd0, 6'd0);
    send_item(CMD_ALLOC, 4'd0, 6'd0);
    send_item(CMD_FREE, 4'd15, 6'd0);
    send_item(CMD_FREE, 4'd0, 6'd63);
    send_item(CMD_FREE, 4'd9, 6'd9);

    idle_for(1);
    while (n_pending != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("summary: %0d items sent, %0d results strobed", items_sent, results_seen);
    $display("summary: %0d out-of-space and %0d stack-full answers seen",
             no_space_seen, overflow_seen);
    if (n_failures == 0 && n_pending == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule
